// ----- hw/rtl/pxc_pkg.sv -----
// Package for the pixel to RGBA8888 converter.
// Holds source format codes, layout classes, the words passed between stages
// and the field widening helpers. No dependencies.
package pxc_pkg;

  // Source format codes as written to the format register
  localparam logic [3:0] FMT_A8       = 4'd0;
  localparam logic [3:0] FMT_L8       = 4'd1;
  localparam logic [3:0] FMT_LA88     = 4'd2;
  localparam logic [3:0] FMT_RGB565   = 4'd3;
  localparam logic [3:0] FMT_BGR565   = 4'd4;
  localparam logic [3:0] FMT_RGB888   = 4'd5;
  localparam logic [3:0] FMT_RGB8888  = 4'd6;
  localparam logic [3:0] FMT_BGR8888  = 4'd7;
  localparam logic [3:0] FMT_RGBA8888 = 4'd8;
  localparam logic [3:0] FMT_BGRA8888 = 4'd9;
  localparam logic [3:0] FMT_RGBA4444 = 4'd10;
  localparam logic [3:0] FMT_BGRA4444 = 4'd11;
  localparam logic [3:0] FMT_RGBA5551 = 4'd12;
  localparam logic [3:0] FMT_BGRA5551 = 4'd13;

  localparam logic [3:0] FMT_RESET    = FMT_RGBA8888;

  // Byte layout class of a format
  typedef enum logic [2:0] {
    LAYOUT_NONE,     // no color, no alpha (L8, unsupported)
    LAYOUT_A_BYTE0,  // alpha in byte 0
    LAYOUT_A_BYTE1,  // alpha in byte 1
    LAYOUT_565,
    LAYOUT_8888,     // one byte per channel
    LAYOUT_4444,
    LAYOUT_5551
  } layout_e;

  // Decoded control that travels with each word
  typedef struct packed {
    layout_e layout;
    logic    swap_rb;    // first channel is blue
    logic    has_alpha;  // 8888 layout carries alpha in byte 3
  } ctrl_t;

  // Source bytes of one pixel
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } bytes_t;

  // Unpacked, right-justified raw fields
  typedef struct packed {
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic [7:0] ch3;
    logic [7:0] alpha;
  } raw_t;

  // Output color
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  // Widening: shift left, OR in the field's own low bits
  function automatic logic [7:0] wide5(logic [4:0] v);
    return {v, v[2:0]};
  endfunction

  function automatic logic [7:0] wide6(logic [5:0] v);
    return {v, v[1:0]};
  endfunction

  function automatic logic [7:0] wide4(logic [3:0] v);
    return {v, v};
  endfunction

endpackage

// ----- hw/rtl/pxc_decode_stage.sv -----
// First pipeline stage: registers the source bytes and decodes the format
// code into a layout class. Depends on pxc_pkg.
module pxc_decode_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [3:0]     fmt_i,
  input  pxc_pkg::bytes_t bytes_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pxc_pkg::ctrl_t out_ctrl_o,
  output pxc_pkg::bytes_t out_bytes_o
);

  logic            valid_q, valid_d;
  pxc_pkg::ctrl_t  ctrl_q, ctrl_d;
  pxc_pkg::bytes_t bytes_q;
  logic            load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (valid_q && !out_ready_i);

  // Format code to layout class
  always_comb begin
    ctrl_d = '{layout: pxc_pkg::LAYOUT_NONE, swap_rb: 1'b0, has_alpha: 1'b0};
    unique case (fmt_i)
      pxc_pkg::FMT_A8:       ctrl_d.layout = pxc_pkg::LAYOUT_A_BYTE0;
      pxc_pkg::FMT_L8:       ctrl_d.layout = pxc_pkg::LAYOUT_NONE;
      pxc_pkg::FMT_LA88:     ctrl_d.layout = pxc_pkg::LAYOUT_A_BYTE1;
      pxc_pkg::FMT_RGB565:   ctrl_d.layout = pxc_pkg::LAYOUT_565;
      pxc_pkg::FMT_BGR565: begin
        ctrl_d.layout  = pxc_pkg::LAYOUT_565;
        ctrl_d.swap_rb = 1'b1;
      end
      pxc_pkg::FMT_RGB888,
      pxc_pkg::FMT_RGB8888:  ctrl_d.layout = pxc_pkg::LAYOUT_8888;
      pxc_pkg::FMT_BGR8888: begin
        ctrl_d.layout  = pxc_pkg::LAYOUT_8888;
        ctrl_d.swap_rb = 1'b1;
      end
      pxc_pkg::FMT_RGBA8888: begin
        ctrl_d.layout    = pxc_pkg::LAYOUT_8888;
        ctrl_d.has_alpha = 1'b1;
      end
      pxc_pkg::FMT_BGRA8888: begin
        ctrl_d.layout    = pxc_pkg::LAYOUT_8888;
        ctrl_d.swap_rb   = 1'b1;
        ctrl_d.has_alpha = 1'b1;
      end
      pxc_pkg::FMT_RGBA4444: ctrl_d.layout = pxc_pkg::LAYOUT_4444;
      pxc_pkg::FMT_BGRA4444: begin
        ctrl_d.layout  = pxc_pkg::LAYOUT_4444;
        ctrl_d.swap_rb = 1'b1;
      end
      pxc_pkg::FMT_RGBA5551: ctrl_d.layout = pxc_pkg::LAYOUT_5551;
      pxc_pkg::FMT_BGRA5551: begin
        ctrl_d.layout  = pxc_pkg::LAYOUT_5551;
        ctrl_d.swap_rb = 1'b1;
      end
      default:               ctrl_d.layout = pxc_pkg::LAYOUT_NONE;
    endcase
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q  <= ctrl_d;
      bytes_q <= bytes_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ctrl_o  = ctrl_q;
  assign out_bytes_o = bytes_q;

endmodule

// ----- hw/rtl/pxc_unpack_stage.sv -----
// Second pipeline stage: cuts the source bytes into raw channel fields per
// layout class. Depends on pxc_pkg.
module pxc_unpack_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pxc_pkg::ctrl_t  ctrl_i,
  input  pxc_pkg::bytes_t bytes_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pxc_pkg::ctrl_t  out_ctrl_o,
  output pxc_pkg::raw_t   out_raw_o
);

  logic           valid_q, valid_d;
  pxc_pkg::ctrl_t ctrl_q;
  pxc_pkg::raw_t  raw_q, raw_d;
  logic           load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (valid_q && !out_ready_i);

  // Field extraction
  always_comb begin
    raw_d = '0;
    unique case (ctrl_i.layout)
      pxc_pkg::LAYOUT_A_BYTE0: raw_d.alpha = bytes_i.b0;
      pxc_pkg::LAYOUT_A_BYTE1: raw_d.alpha = bytes_i.b1;
      pxc_pkg::LAYOUT_565: begin
        raw_d.ch1 = {3'b000, bytes_i.b0[7:3]};
        raw_d.ch2 = {2'b00, bytes_i.b0[2:0], bytes_i.b1[7:5]};
        raw_d.ch3 = {3'b000, bytes_i.b1[4:0]};
      end
      pxc_pkg::LAYOUT_8888: begin
        raw_d.ch1   = bytes_i.b0;
        raw_d.ch2   = bytes_i.b1;
        raw_d.ch3   = bytes_i.b2;
        raw_d.alpha = ctrl_i.has_alpha ? bytes_i.b3 : 8'h00;
      end
      pxc_pkg::LAYOUT_4444: begin
        raw_d.ch1   = {4'h0, bytes_i.b0[7:4]};
        raw_d.ch2   = {4'h0, bytes_i.b0[3:0]};
        raw_d.ch3   = {4'h0, bytes_i.b1[7:4]};
        raw_d.alpha = {4'h0, bytes_i.b1[3:0]};
      end
      pxc_pkg::LAYOUT_5551: begin
        raw_d.ch1   = {3'b000, bytes_i.b0[7:3]};
        raw_d.ch2   = {3'b000, bytes_i.b0[2:0], bytes_i.b1[7:6]};
        raw_d.ch3   = {3'b000, bytes_i.b1[5:1]};
        raw_d.alpha = {7'h00, bytes_i.b1[0]};
      end
      default:                 raw_d = '0;
    endcase
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      ctrl_q <= ctrl_i;
      raw_q  <= raw_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_ctrl_o  = ctrl_q;
  assign out_raw_o   = raw_q;

endmodule

// ----- hw/rtl/pxc_widen_stage.sv -----
// Third pipeline stage and output register: widens raw fields to eight bits
// and routes them to red, green, blue, alpha. Depends on pxc_pkg.
module pxc_widen_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pxc_pkg::ctrl_t ctrl_i,
  input  pxc_pkg::raw_t  raw_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pxc_pkg::rgba_t out_rgba_o
);

  logic           valid_q, valid_d;
  pxc_pkg::rgba_t rgba_q, rgba_d;
  logic [7:0]     c1, c2, c3;
  logic           load;

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (valid_q && !out_ready_i);

  // Widen per layout, then place first and third channel
  always_comb begin
    c1           = 8'h00;
    c2           = 8'h00;
    c3           = 8'h00;
    rgba_d.alpha = 8'h00;
    unique case (ctrl_i.layout)
      pxc_pkg::LAYOUT_A_BYTE0,
      pxc_pkg::LAYOUT_A_BYTE1: rgba_d.alpha = raw_i.alpha;
      pxc_pkg::LAYOUT_565: begin
        c1 = pxc_pkg::wide5(raw_i.ch1[4:0]);
        c2 = pxc_pkg::wide6(raw_i.ch2[5:0]);
        c3 = pxc_pkg::wide5(raw_i.ch3[4:0]);
      end
      pxc_pkg::LAYOUT_8888: begin
        c1           = raw_i.ch1;
        c2           = raw_i.ch2;
        c3           = raw_i.ch3;
        rgba_d.alpha = raw_i.alpha;
      end
      pxc_pkg::LAYOUT_4444: begin
        c1           = pxc_pkg::wide4(raw_i.ch1[3:0]);
        c2           = pxc_pkg::wide4(raw_i.ch2[3:0]);
        c3           = pxc_pkg::wide4(raw_i.ch3[3:0]);
        rgba_d.alpha = pxc_pkg::wide4(raw_i.alpha[3:0]);
      end
      pxc_pkg::LAYOUT_5551: begin
        c1           = pxc_pkg::wide5(raw_i.ch1[4:0]);
        c2           = pxc_pkg::wide5(raw_i.ch2[4:0]);
        c3           = pxc_pkg::wide5(raw_i.ch3[4:0]);
        rgba_d.alpha = {8{raw_i.alpha[0]}};
      end
      default: begin
        c1           = 8'h00;
        rgba_d.alpha = 8'h00;
      end
    endcase
    rgba_d.green = c2;
    rgba_d.red   = ctrl_i.swap_rb ? c3 : c1;
    rgba_d.blue  = ctrl_i.swap_rb ? c1 : c3;
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      rgba_q <= rgba_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rgba_o  = rgba_q;

endmodule

// ----- hw/rtl/pixel_to_rgba8888_converter_unit.sv -----
// Pixel to RGBA8888 converter: top level with the source format register
// and the three stage pipeline. Depends on pxc_pkg and the pxc stage modules.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one source pixel word as
//   four bytes in memory order. Output channel (out_valid_o / out_ready_i)
//   gives one word of 8-bit red, green, blue and alpha for each input word.
//   The source format register is written through cfg_we_i / cfg_wdata_i
//   and is sampled as a word enters; change it only while the pipeline is
//   empty.
// Path: a word passes through the decode, unpack and widen registers in
//   that order; the widen register is the output register.
// Throughput: one word per cycle while out_ready_i stays high.
// Reset: all valid bits clear, the pipeline is empty, the format register
//   returns to RGBA8888.
// Stall: with out_ready_i low, each stage holds its word; earlier stages
//   keep filling bubbles, and in_ready_o drops only when all three stages
//   hold a word.
module pixel_to_rgba8888_converter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] pixel_byte0_i,
  input  logic [7:0] pixel_byte1_i,
  input  logic [7:0] pixel_byte2_i,
  input  logic [7:0] pixel_byte3_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o
);

  logic [3:0]      fmt_q;
  pxc_pkg::bytes_t in_bytes;
  logic            dec_valid, dec_ready;
  pxc_pkg::ctrl_t  dec_ctrl;
  pxc_pkg::bytes_t dec_bytes;
  logic            unp_valid, unp_ready;
  pxc_pkg::ctrl_t  unp_ctrl;
  pxc_pkg::raw_t   unp_raw;
  pxc_pkg::rgba_t  out_rgba;

  // Source format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= pxc_pkg::FMT_RESET;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  assign in_bytes = '{b0: pixel_byte0_i, b1: pixel_byte1_i,
                      b2: pixel_byte2_i, b3: pixel_byte3_i};

  pxc_decode_stage u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .fmt_i       (fmt_q),
    .bytes_i     (in_bytes),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_ctrl_o  (dec_ctrl),
    .out_bytes_o (dec_bytes)
  );

  pxc_unpack_stage u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .ctrl_i      (dec_ctrl),
    .bytes_i     (dec_bytes),
    .out_valid_o (unp_valid),
    .out_ready_i (unp_ready),
    .out_ctrl_o  (unp_ctrl),
    .out_raw_o   (unp_raw)
  );

  pxc_widen_stage u_widen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (unp_valid),
    .in_ready_o  (unp_ready),
    .ctrl_i      (unp_ctrl),
    .raw_i       (unp_raw),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rgba_o  (out_rgba)
  );

  assign out_red_o   = out_rgba.red;
  assign out_green_o = out_rgba.green;
  assign out_blue_o  = out_rgba.blue;
  assign out_alpha_o = out_rgba.alpha;

`ifndef NO_ASSERTIONS
  // Input backpressure only when every stage is full and the sink stalls
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (dec_valid && unp_valid && out_valid_o && !out_ready_i))
    else $error("input stalled while pipeline has room");

  // A decoded word moves into the unpack stage when it has room
  a_dec_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec_valid && dec_ready) |=> unp_valid)
    else $error("word lost between decode and unpack");

  // A word without color or alpha leaves as all zero
  a_none_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (unp_valid && unp_ready && (unp_ctrl.layout == pxc_pkg::LAYOUT_NONE))
      |=> (out_valid_o && (out_rgba == '0)))
    else $error("unsupported format gave nonzero output");
`endif

endmodule

// ----- bench/pxc_rgba_checker.sv -----
// Checker for the pixel to RGBA8888 converter: watches the config port and
// both channels, predicts each output word and compares it field by field.
// Depends on pxc_pkg for format codes and word types.
`timescale 1ns / 1ps

module pxc_rgba_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] pixel_byte0_i,
  input  logic [7:0] pixel_byte1_i,
  input  logic [7:0] pixel_byte2_i,
  input  logic [7:0] pixel_byte3_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_red_i,
  input  logic [7:0] out_green_i,
  input  logic [7:0] out_blue_i,
  input  logic [7:0] out_alpha_i,
  output int         fail_count_o,
  output int         pending_o
);

  logic [3:0]     src_fmt;
  pxc_pkg::rgba_t expected_rgba [$];
  int             mismatches;
  string          chan_name [4] = '{"red", "green", "blue", "alpha"};

  // Widen a narrow field: shift to the top, fill with the field's low bits
  function automatic logic [7:0] widen(input logic [7:0] v, input int bits);
    int lo;
    lo = 8 - bits;
    return 8'((v << lo) | (v & ((1 << lo) - 1)));
  endfunction

  // Expected color for one source pixel under a given format
  function automatic pxc_pkg::rgba_t predict_rgba(input logic [3:0] fmt,
                                                  input pxc_pkg::bytes_t px);
    pxc_pkg::rgba_t c;
    logic [7:0]     f1, f2, f3;
    c = '0;
    case (fmt)
      pxc_pkg::FMT_A8:   c.alpha = px.b0;
      pxc_pkg::FMT_L8:   ;  // luminance dropped, nothing survives
      pxc_pkg::FMT_LA88: c.alpha = px.b1;
      pxc_pkg::FMT_RGB565, pxc_pkg::FMT_BGR565: begin
        f1 = widen({3'b000, px.b0[7:3]}, 5);
        f2 = widen({2'b00, px.b0[2:0], px.b1[7:5]}, 6);
        f3 = widen({3'b000, px.b1[4:0]}, 5);
        c.green = f2;
        if (fmt == pxc_pkg::FMT_RGB565) {c.red, c.blue} = {f1, f3};
        else {c.red, c.blue} = {f3, f1};
      end
      pxc_pkg::FMT_RGB888, pxc_pkg::FMT_RGB8888:
        {c.red, c.green, c.blue} = {px.b0, px.b1, px.b2};
      pxc_pkg::FMT_BGR8888: {c.blue, c.green, c.red} = {px.b0, px.b1, px.b2};
      pxc_pkg::FMT_RGBA8888: c = {px.b0, px.b1, px.b2, px.b3};
      pxc_pkg::FMT_BGRA8888: c = {px.b2, px.b1, px.b0, px.b3};
      pxc_pkg::FMT_RGBA4444, pxc_pkg::FMT_BGRA4444: begin
        f1 = widen({4'h0, px.b0[7:4]}, 4);
        f2 = widen({4'h0, px.b0[3:0]}, 4);
        f3 = widen({4'h0, px.b1[7:4]}, 4);
        c.green = f2;
        c.alpha = widen({4'h0, px.b1[3:0]}, 4);
        if (fmt == pxc_pkg::FMT_RGBA4444) {c.red, c.blue} = {f1, f3};
        else {c.red, c.blue} = {f3, f1};
      end
      pxc_pkg::FMT_RGBA5551, pxc_pkg::FMT_BGRA5551: begin
        f1 = widen({3'b000, px.b0[7:3]}, 5);
        f2 = widen({3'b000, px.b0[2:0], px.b1[7:6]}, 5);
        f3 = widen({3'b000, px.b1[5:1]}, 5);
        c.green = f2;
        c.alpha = px.b1[0] ? 8'hFF : 8'h00;
        if (fmt == pxc_pkg::FMT_RGBA5551) {c.red, c.blue} = {f1, f3};
        else {c.red, c.blue} = {f3, f1};
      end
      default: c = '0;  // unassigned or invalid source code
    endcase
    return c;
  endfunction

  // Track the format, queue predictions, score output words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    pxc_pkg::rgba_t want, got;
    bit             bad;
    if (!rst_ni) begin
      src_fmt <= pxc_pkg::FMT_RESET;
      expected_rgba.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) src_fmt <= cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        expected_rgba.push_back(predict_rgba(src_fmt,
          {pixel_byte0_i, pixel_byte1_i, pixel_byte2_i, pixel_byte3_i}));
      if (out_valid_i && out_ready_i) begin
        got = {out_red_i, out_green_i, out_blue_i, out_alpha_i};
        if (expected_rgba.size() == 0) begin
          $display("%0t: unexpected output word %08h", $time, got);
          mismatches++;
        end else begin
          want = expected_rgba.pop_front();
          bad = 0;
          for (int k = 0; k < 4; k++) begin
            if (got[31-8*k -: 8] !== want[31-8*k -: 8]) begin
              $display("%0t: %s mismatch: expected %02h, got %02h", $time,
                       chan_name[k], want[31-8*k -: 8], got[31-8*k -: 8]);
              bad = 1;
            end
          end
          if (bad) mismatches++;
        end
      end
      fail_count_o <= mismatches;
      pending_o <= expected_rgba.size();
    end
  end

endmodule

// ----- bench/tb.sv -----
// Top of the converter bench: clock, reset, format writes, pixel stimulus
// and output back-pressure. Scoring lives in pxc_rgba_checker.
// Depends on pxc_rgba_checker and pixel_to_rgba8888_converter_unit.
`timescale 1ns / 1ps

module tb;

  // Codes past the supported range, all decode to zero output
  localparam logic [3:0] FMT_OTHER = 4'd14;
  localparam logic [3:0] FMT_SPARE = 4'd15;
  localparam int NUM_CHUNKS  = 30;
  localparam int CHUNK_WORDS = 30;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] byte0 = '0, byte1 = '0, byte2 = '0, byte3 = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  int         fail_count, pending;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;
  int         words_sent = 0;
  int         fmt_writes = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pixel_to_rgba8888_converter_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .pixel_byte0_i (byte0),
    .pixel_byte1_i (byte1),
    .pixel_byte2_i (byte2),
    .pixel_byte3_i (byte3),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_red_o     (out_red),
    .out_green_o   (out_green),
    .out_blue_o    (out_blue),
    .out_alpha_o   (out_alpha)
  );

  pxc_rgba_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .pixel_byte0_i (byte0),
    .pixel_byte1_i (byte1),
    .pixel_byte2_i (byte2),
    .pixel_byte3_i (byte3),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_red_i     (out_red),
    .out_green_i   (out_green),
    .out_blue_i    (out_blue),
    .out_alpha_i   (out_alpha),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Byte with extra weight on the extremes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel word, returns at the edge where it is taken
  task automatic send_pixel(input logic [7:0] p0, p1, p2, p3);
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    {byte0, byte1, byte2, byte3} <= {p0, p1, p2, p3};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    words_sent++;
  endtask

  // Stop sending and wait for every predicted word to come out
  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Format write, only with the pipeline empty
  task automatic write_format(input logic [3:0] fmt);
    drain_words();
    cfg_we <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    fmt_writes++;
  endtask

  task automatic set_idle_mix(input int mix);
    case (mix)
      0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1:       begin tx_idle_pct = 53; rx_stall_pct = 0;  end
      2:       begin tx_idle_pct = 0;  rx_stall_pct = 53; end
      default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
    endcase
  endtask

  // Stimulus
  initial begin
    logic [3:0] fmt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset format is RGBA8888: check it before any write
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // One word per format code, unsupported codes included.
    // Odd codes see an alpha bit of one in 5551, even codes zero.
    for (int f = 0; f < 16; f++) begin
      write_format(4'(f));
      if (f % 2 == 0) send_pixel(8'hFF, 8'hFE, 8'h80, 8'h01);
      else send_pixel(8'h00, 8'h01, 8'h7F, 8'hFE);
    end

    // Random chunks: walk every format first, then random ones, ending
    // with the two spare codes, rotating through the idle and stall mixes
    for (int ch = 0; ch < NUM_CHUNKS; ch++) begin
      if (ch < 16) fmt = 4'(ch);
      else if (ch == NUM_CHUNKS - 2) fmt = FMT_SPARE;
      else if (ch == NUM_CHUNKS - 1) fmt = FMT_OTHER;
      else fmt = 4'($urandom_range(0, 15));
      write_format(fmt);
      set_idle_mix(ch % 4);
      repeat (CHUNK_WORDS) send_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    end

    set_idle_mix(0);
    drain_words();
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d pixel words over %0d format writes (codes 0 to 15),",
             words_sent, fmt_writes);
    $display("Summary: with free flow, sender gaps, receiver stalls and both mixed.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
